### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decorrelator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("decorrelator assertion failed");

// Check a property on every clock edge, reset included.
`define MFD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("decorrelator assertion failed");

`endif

### rtl/core/mfd_pkg.sv
// ---------------------------------------------------------------------------
// Decorrelator package
// Sizes, codes, shared types and address helpers.
// ---------------------------------------------------------------------------
package mfd_pkg;

  localparam int CHANNELS    = 16;
  localparam int TAPS        = 512;
  localparam int DELAY_DEPTH = 512;
  localparam int SAMPLE_BITS = 24;

  localparam int CH_W      = 4;
  localparam int IDX_W     = 9;
  localparam int DLY_CFG_W = 9;

  localparam int CHAN_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TAP_W   = $clog2(TAPS);
  localparam int DLY_W   = $clog2(DELAY_DEPTH);
  localparam int HIST_AW = $clog2(CHANNELS * TAPS);
  localparam int DIR_AW  = $clog2(CHANNELS * DELAY_DEPTH);
  localparam int CLR_N   = CHANNELS * ((TAPS > DELAY_DEPTH) ? TAPS : DELAY_DEPTH);
  localparam int CLR_W   = $clog2(CLR_N);
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + TAP_W + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;
  localparam logic CFG_SLOT_DELAY = 1'b0;
  localparam logic [DLY_CFG_W-1:0] DELAY_RESET = DLY_CFG_W'(256);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = sample_t'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(longint'(1) << (SAMPLE_BITS - 1));

  typedef struct packed {
    logic                 command;
    logic [CH_W-1:0]      channel;
    sample_t              direct;
    sample_t              diffuse;
    logic [IDX_W-1:0]     coef_index;
    sample_t              coef_value;
  } q_word_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [HIST_AW-1:0] hist_addr(input logic [CHAN_AW-1:0] ch,
                                                   input logic [TAP_W-1:0] tap);
    return HIST_AW'(ch) * HIST_AW'(TAPS) + HIST_AW'(tap);
  endfunction

  function automatic logic [DIR_AW-1:0] dir_addr(input logic [CHAN_AW-1:0] ch,
                                                 input logic [DLY_W-1:0] pos);
    return DIR_AW'(ch) * DIR_AW'(DELAY_DEPTH) + DIR_AW'(pos);
  endfunction

endpackage

### rtl/core/mfd_if.sv
// ---------------------------------------------------------------------------
// Decorrelator stream interfaces
// Valid/ready channels for input words and result words.
// ---------------------------------------------------------------------------
interface mfd_in_if;
  import mfd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [CH_W-1:0]      channel;
  logic signed [SAMPLE_BITS-1:0] direct_sample;
  logic signed [SAMPLE_BITS-1:0] diffuse_sample;
  logic [IDX_W-1:0]     coef_index;
  logic signed [SAMPLE_BITS-1:0] coef_value;

  modport source (output valid, command, channel, direct_sample, diffuse_sample,
                  coef_index, coef_value, input ready);
  modport sink   (input valid, command, channel, direct_sample, diffuse_sample,
                  coef_index, coef_value, output ready);
endinterface

interface mfd_out_if;
  import mfd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CH_W-1:0]      out_channel;
  logic signed [SAMPLE_BITS-1:0] direct_out;
  logic signed [SAMPLE_BITS-1:0] diffuse_out;
  logic                 saturated;

  modport source (output valid, out_channel, direct_out, diffuse_out, saturated,
                  input ready);
  modport sink   (input valid, out_channel, direct_out, diffuse_out, saturated,
                  output ready);
endinterface

### rtl/core/mfd_front.sv
// ---------------------------------------------------------------------------
// Decorrelator front end
// Accept input words, drop the ones that address nothing, queue the rest.
// ---------------------------------------------------------------------------
module mfd_front (
  mfd_in_if.sink           in_i,
  input  logic             clearing_i,
  input  mfd_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output mfd_pkg::q_word_t push_word_o
);
  import mfd_pkg::*;

  logic keep;

  // Drop unknown channels and loads beyond the last tap.
  assign keep = (32'(in_i.channel) < CHANNELS) &&
                !((in_i.command == CMD_LOAD) && (32'(in_i.coef_index) >= TAPS));

  assign in_i.ready = !clearing_i && !q_stat_i.full;
  assign push_o     = in_i.valid && in_i.ready && keep;

  always_comb begin
    push_word_o.command    = in_i.command;
    push_word_o.channel    = in_i.channel;
    push_word_o.direct     = in_i.direct_sample;
    push_word_o.diffuse    = in_i.diffuse_sample;
    push_word_o.coef_index = in_i.coef_index;
    push_word_o.coef_value = in_i.coef_value;
  end

endmodule

### rtl/core/mfd_queue.sv
// ---------------------------------------------------------------------------
// Decorrelator command queue
// Short FIFO that decouples the front end from the filter engine.
// ---------------------------------------------------------------------------
module mfd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfd_pkg::q_word_t push_word_i,
  input  logic             pop_i,
  output mfd_pkg::q_word_t pop_word_o,
  output mfd_pkg::q_stat_t stat_o
);
  import mfd_pkg::*;

  q_word_t           ent_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_q, rd_q;
  logic [Q_AW:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == Q_DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == Q_DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_word_i;
    end
  end

  assign pop_word_o   = ent_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (32'(cnt_q) == Q_DEPTH);

endmodule

### rtl/core/mfd_back.sv
// ---------------------------------------------------------------------------
// Decorrelator filter engine
// Delay line, coefficient store and shared multiply-accumulate per channel.
// ---------------------------------------------------------------------------
module mfd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mfd_pkg::DLY_CFG_W-1:0] delay_i,
  input  mfd_pkg::q_stat_t              q_stat_i,
  input  mfd_pkg::q_word_t              q_word_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  mfd_out_if.source                     out_o
);
  import mfd_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DREAD = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  typedef logic signed [ACC_W:0] wide_t;
  localparam wide_t RND_HALF = wide_t'(longint'(1) << (SAMPLE_BITS - 2));
  localparam wide_t SAT_HI   = wide_t'(SAMPLE_MAX);
  localparam wide_t SAT_LO   = wide_t'(SAMPLE_MIN);

  sample_t dir_mem  [CHANNELS*DELAY_DEPTH];
  sample_t hist_mem [CHANNELS*TAPS];
  sample_t coef_mem [CHANNELS*TAPS];

  logic [2:0]          state_q, state_d;
  logic [CLR_W-1:0]    clr_q;
  logic [CH_W-1:0]     ch_q;
  logic [DLY_W-1:0]    wp_q;
  logic [TAP_W-1:0]    hp_q, k_q;
  logic [DLY_W-1:0]    wptr_q [CHANNELS];
  logic [TAP_W-1:0]    hptr_q [CHANNELS];
  logic                rv_q, pv_q;
  sample_t             coef_rd_q, hist_rd_q, dir_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic                out_valid_q;
  logic [CH_W-1:0]     out_ch_q;
  sample_t             out_dir_q, out_dif_q;
  logic                out_sat_q;

  logic [CHAN_AW-1:0]  cidx, chq_idx;
  logic [DLY_W-1:0]    wp_cur, wp_nxt, dly_mod;
  logic [DLY_W:0]      rp_wide;
  logic [TAP_W-1:0]    hp_new;
  logic [TAP_W:0]      tap_wide;
  logic                take_proc, take_load, mac_re, out_load;
  logic                dir_we, hist_we, coef_we;
  logic [DIR_AW-1:0]   dir_wa, dir_ra;
  logic [HIST_AW-1:0]  hist_wa, hist_ra, coef_wa, coef_ra;
  sample_t             dir_wd, hist_wd;
  wide_t               rnd_sum, rnd_y;

  assign cidx    = CHAN_AW'(q_word_i.channel);
  assign chq_idx = CHAN_AW'(ch_q);

  assign pop_o      = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign take_proc  = pop_o && (q_word_i.command == CMD_PROCESS);
  assign take_load  = pop_o && (q_word_i.command == CMD_LOAD);
  assign clearing_o = (state_q == ST_CLEAR);

  // Advance per-channel pointers.
  assign wp_cur = wptr_q[cidx];
  assign wp_nxt = (32'(wp_cur) == DELAY_DEPTH - 1) ? '0 : wp_cur + 1'b1;
  assign hp_new = (32'(hptr_q[cidx]) == TAPS - 1) ? '0 : hptr_q[cidx] + 1'b1;

  // Read pointer trails the write pointer by the delay, wrapped.
  assign dly_mod = DLY_W'(delay_i % DELAY_DEPTH);
  assign rp_wide = (wp_q >= dly_mod) ? {1'b0, wp_q} - {1'b0, dly_mod}
                                     : {1'b0, wp_q} + (DLY_W+1)'(DELAY_DEPTH)
                                       - {1'b0, dly_mod};
  assign dir_ra  = dir_addr(chq_idx, rp_wide[DLY_W-1:0]);

  // Tap k pairs h[k] with the sample k steps older than the newest.
  assign tap_wide = (hp_q >= k_q) ? {1'b0, hp_q} - {1'b0, k_q}
                                  : {1'b0, hp_q} + (TAP_W+1)'(TAPS) - {1'b0, k_q};
  assign hist_ra  = hist_addr(chq_idx, tap_wide[TAP_W-1:0]);
  assign coef_ra  = hist_addr(chq_idx, k_q);
  assign mac_re   = (state_q == ST_MAC);

  always_comb begin
    dir_we  = 1'b0;
    dir_wa  = dir_addr(cidx, wp_cur);
    dir_wd  = q_word_i.direct;
    hist_we = 1'b0;
    hist_wa = hist_addr(cidx, hp_new);
    hist_wd = q_word_i.diffuse;
    coef_we = take_load;
    coef_wa = hist_addr(cidx, TAP_W'(q_word_i.coef_index));
    if (state_q == ST_CLEAR) begin
      dir_we  = 32'(clr_q) < CHANNELS * DELAY_DEPTH;
      dir_wa  = DIR_AW'(clr_q);
      dir_wd  = '0;
      hist_we = 32'(clr_q) < CHANNELS * TAPS;
      hist_wa = HIST_AW'(clr_q);
      hist_wd = '0;
    end else if (take_proc) begin
      dir_we  = 1'b1;
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (state_q == ST_DREAD) begin
      dir_rd_q <= dir_mem[dir_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (mac_re) begin
      hist_rd_q <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= q_word_i.coef_value;
    end
    if (mac_re) begin
      coef_rd_q <= coef_mem[coef_ra];
    end
  end

  // Round half up, then clip to the sample range.
  assign rnd_sum  = wide_t'(acc_q) + RND_HALF;
  assign rnd_y    = rnd_sum >>> (SAMPLE_BITS - 1);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == CLR_N - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_proc) begin
          state_d = ST_DREAD;
        end
      end
      ST_DREAD: state_d = ST_MAC;
      ST_MAC: begin
        if (32'(k_q) == TAPS - 1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rv_q && !pv_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rv_q        <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wptr_q[i] <= '0;
        hptr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      rv_q    <= mac_re;
      pv_q    <= rv_q;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (take_proc) begin
        wptr_q[cidx] <= wp_nxt;
        hptr_q[cidx] <= hp_new;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_proc) begin
      ch_q <= q_word_i.channel;
      wp_q <= wp_cur;
      hp_q <= hp_new;
    end
    if (state_q == ST_DREAD) begin
      k_q   <= '0;
      acc_q <= '0;
    end else begin
      if (mac_re) begin
        k_q <= k_q + 1'b1;
      end
      if (pv_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
    if (rv_q) begin
      prod_q <= coef_rd_q * hist_rd_q;
    end
    if (out_load) begin
      out_ch_q  <= ch_q;
      out_dir_q <= dir_rd_q;
      out_sat_q <= (rnd_y > SAT_HI) || (rnd_y < SAT_LO);
      if (rnd_y > SAT_HI) begin
        out_dif_q <= SAMPLE_MAX;
      end else if (rnd_y < SAT_LO) begin
        out_dif_q <= SAMPLE_MIN;
      end else begin
        out_dif_q <= sample_t'(rnd_y);
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.direct_out  = out_dir_q;
  assign out_o.diffuse_out = out_dif_q;
  assign out_o.saturated   = out_sat_q;

endmodule

### rtl/core/multichannel_fir_decorrelator_unit.sv
// ---------------------------------------------------------------------------
// Multichannel FIR decorrelator
// Per-channel direct-path delay plus FIR decorrelation of the diffuse path.
// ---------------------------------------------------------------------------
// In the filter engine a sample-pair word takes one multiply-accumulate per
// tap through a single shared multiplier that reads one coefficient and one
// history sample per cycle from per-channel memories. A coefficient-load
// word is stored as it is taken, and the engine stays idle. The front end
// queues up to two words while the engine works, and the result register
// holds a finished word while the next one is processed. After reset a
// clearing pass over CHANNELS * max(TAPS, DELAY_DEPTH) addresses zeroes the
// delay and history memories; no input word is taken during it, while
// register writes are served as usual. The delay register lives at byte
// address 0 and is written with an APB setup phase and access phase.
module multichannel_fir_decorrelator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mfd_in_if.sink                      in_i,
  mfd_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mfd_pkg::PADDR_W-1:0] paddr,
  input  logic [mfd_pkg::PDATA_W-1:0] pwdata,
  output logic [mfd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import mfd_pkg::*;

  logic [DLY_CFG_W-1:0] delay_q;
  logic                 cfg_hit;
  logic                 push, pop, clearing;
  q_word_t              push_word, pop_word;
  q_stat_t              q_stat;

  // Register file: one word-wide register, addressed by paddr[2].
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == CFG_SLOT_DELAY);
  assign prdata  = cfg_hit ? PDATA_W'(delay_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      delay_q <= pwdata[DLY_CFG_W-1:0];
    end
  end

  // Front end: classify and drop words that address nothing.
  mfd_front u_front (
    .in_i        (in_i),
    .clearing_i  (clearing),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_word_o (push_word)
  );

  // Hold pending words between front and engine.
  mfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .pop_i       (pop),
    .pop_word_o  (pop_word),
    .stat_o      (q_stat)
  );

  // Engine: delay line, coefficient loads, MAC, rounding and clipping.
  mfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .delay_i    (delay_q),
    .q_stat_i   (q_stat),
    .q_word_i   (pop_word),
    .pop_o      (pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

endmodule

### rtl/core/mfd_checker.sv
// ---------------------------------------------------------------------------
// Decorrelator port checker
// Watch the result channel and register port of the top level over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pready,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mfd_pkg::CH_W-1:0]      out_channel_i,
  input logic signed [mfd_pkg::SAMPLE_BITS-1:0] out_diffuse_i,
  input logic                          out_sat_i
);
  import mfd_pkg::*;

  `MFD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_diffuse_i))
  `MFD_ASSERT(a_sat_clip, clk_i, rst_ni, out_valid_i && out_sat_i |-> out_diffuse_i == SAMPLE_MAX || out_diffuse_i == SAMPLE_MIN)
  `MFD_ASSERT(a_chan_range, clk_i, rst_ni, out_valid_i |-> 32'(out_channel_i) < CHANNELS)
  `MFD_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind multichannel_fir_decorrelator_unit mfd_checker u_mfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_channel_i (out_o.out_channel),
  .out_diffuse_i (out_o.diffuse_out),
  .out_sat_i     (out_o.saturated)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Decorrelator unit testbench
// Loads every filter tap of every channel, then streams sample-pair and
// coefficient-load words under several delay settings and handshake
// pressures. Each result word is compared with an in-bench predictor.
// ---------------------------------------------------------------------------
module tb;
  import mfd_pkg::*;

  // Carry one directed stimulus row, plus the typed expectation where known.
  typedef struct {
    logic             cmd;
    logic [CH_W-1:0]  ch;
    sample_t          dir;
    sample_t          dif;
    logic [IDX_W-1:0] idx;
    sample_t          val;
    bit               typed;
    sample_t          e_dir;
    sample_t          e_dif;
    logic             e_sat;
  } stim_row_t;

  typedef struct {
    logic [CH_W-1:0] ch;
    sample_t         dir;
    sample_t         dif;
    logic            sat;
  } pair_result_t;

  localparam int DIR_ROWS = 14;
  localparam int ENGINE_DRAIN = 4 * (TAPS + 6);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  mfd_in_if  in_if ();
  mfd_out_if out_if ();

  multichannel_fir_decorrelator_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: delay lines, diffuse history (circular, newest at head),
  // loaded taps and the delay register.
  sample_t        delay_line [CHANNELS][DELAY_DEPTH];
  int unsigned    delay_wp   [CHANNELS];
  sample_t        hist_mem   [CHANNELS][TAPS];
  int unsigned    hist_head  [CHANNELS];
  sample_t        tap_coef   [CHANNELS][TAPS];
  int unsigned    comp_delay;

  pair_result_t pending_pairs [$];
  int errors = 0;
  int n_pairs = 0;
  int n_loads = 0;
  int n_sat = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Directed rows. Channel 0 holds MAX at tap 0 and zero elsewhere; channel 1
  // holds MIN on every tap; stores start cleared and the delay is 256.
  stim_row_t dir_tab [DIR_ROWS] = '{
    // full-scale squared: rounds down to MAX-1, direct path still empty
    '{CMD_PROCESS, 4'd0, SAMPLE_MAX, SAMPLE_MAX, 9'd0, 24'sd0, 1'b1, 24'sd0, 24'sd8388606, 1'b0},
    '{CMD_PROCESS, 4'd0, SAMPLE_MIN, SAMPLE_MIN, 9'd511, SAMPLE_MAX, 1'b1, 24'sd0, -24'sd8388607, 1'b0},
    // MIN times MIN clips to MAX
    '{CMD_PROCESS, 4'd1, 24'sd0, SAMPLE_MIN, 9'd0, 24'sd0, 1'b1, 24'sd0, SAMPLE_MAX, 1'b1},
    '{CMD_PROCESS, 4'd1, -24'sd1, SAMPLE_MAX, 9'd0, 24'sd0, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd1, 24'sd1, 24'sd0, 9'h1FF, SAMPLE_MIN, 1'b0, 24'sd0, 24'sd0, 1'b0},
    // tap index extremes
    '{CMD_LOAD, 4'd2, SAMPLE_MAX, SAMPLE_MIN, 9'd0, SAMPLE_MAX, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_LOAD, 4'd2, SAMPLE_MIN, SAMPLE_MAX, 9'd511, SAMPLE_MIN, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd2, 24'sh555555, SAMPLE_MAX, 9'h0AA, 24'sh2AAAAA, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd15, 24'shAAAAAA, SAMPLE_MIN, 9'h155, 24'sh555555, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_LOAD, 4'd0, 24'sh3C3C3C, 24'shC3C3C3, 9'd511, SAMPLE_MAX, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd0, 24'sh0F0F0F, 24'sd0, 9'd0, 24'sd0, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd0, -24'sd2, 24'sd0, 9'd0, 24'sd0, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_LOAD, 4'd15, 24'sd7, 24'sd9, 9'd256, 24'sd0, 1'b0, 24'sd0, 24'sd0, 1'b0},
    '{CMD_PROCESS, 4'd8, 24'sh123456, SAMPLE_MAX, 9'd3, 24'sd5, 1'b0, 24'sd0, 24'sd0, 1'b0}
  };

  // Pick a tap value scaled by channel: the top channel uses full-range taps
  // and clips often, channel 1 always takes MIN, the others stay mostly in range.
  function automatic sample_t pick_coef(input int ch);
    sample_t raw;
    raw = sample_t'($urandom);
    if (ch == 15) return raw;
    if (ch == 1) return SAMPLE_MIN;
    return raw >>> (6 + ch % 5);
  endfunction

  // Apply one accepted pair to the predictor state and return its result.
  function automatic pair_result_t filter_pair(input logic [CH_W-1:0] ch,
                                               input sample_t dir, input sample_t dif);
    pair_result_t r;
    int unsigned wp, rp;
    longint acc;
    longint y;
    wp = delay_wp[ch];
    delay_line[ch][wp] = dir;
    rp = (wp + DELAY_DEPTH - comp_delay % DELAY_DEPTH) % DELAY_DEPTH;
    r.dir = delay_line[ch][rp];
    delay_wp[ch] = (wp + 1) % DELAY_DEPTH;
    hist_head[ch] = (hist_head[ch] + 1) % TAPS;
    hist_mem[ch][hist_head[ch]] = dif;
    acc = 0;
    for (int k = 0; k < TAPS; k++)
      acc += longint'(hist_mem[ch][(hist_head[ch] + TAPS - k) % TAPS])
           * longint'(tap_coef[ch][k]);
    // round half up, then clip to the sample range
    y = (acc + (longint'(1) << (SAMPLE_BITS - 2))) >>> (SAMPLE_BITS - 1);
    r.sat = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      r.sat = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      r.sat = 1'b1;
    end
    r.dif = sample_t'(y);
    r.ch = ch;
    return r;
  endfunction

  // Offer one word, idling first at random; return once it is accepted.
  task automatic send_word(input logic cmd, input logic [CH_W-1:0] ch,
                           input sample_t dir, input sample_t dif,
                           input logic [IDX_W-1:0] idx, input sample_t val,
                           output bit taken);
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.command        <= cmd;
    in_if.channel        <= ch;
    in_if.direct_sample  <= dir;
    in_if.diffuse_sample <= dif;
    in_if.coef_index     <= idx;
    in_if.coef_value     <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    taken = 1'b1;
    if (cmd == CMD_LOAD) begin
      tap_coef[ch][idx] = val;
      n_loads++;
    end
  endtask

  // Predict a pair word and queue its result (typed rows override the value).
  task automatic send_and_predict(input stim_row_t row);
    bit taken;
    pair_result_t r;
    send_word(row.cmd, row.ch, row.dir, row.dif, row.idx, row.val, taken);
    if (row.cmd == CMD_PROCESS) begin
      r = filter_pair(row.ch, row.dir, row.dif);
      if (row.typed) begin
        r.dir = row.e_dir;
        r.dif = row.e_dif;
        r.sat = row.e_sat;
      end
      pending_pairs = {pending_pairs, r};
      n_pairs++;
    end
  endtask

  // Write the delay register; only called with the block idle.
  task automatic write_delay(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(CFG_SLOT_DELAY));
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    comp_delay = value;
  endtask

  // Hold until every pair has come back, then let trailing loads drain.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (ENGINE_DRAIN) @(posedge clk_i);
  endtask

  // Result side: check the accepted word, then pick the next ready at random.
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    pair_result_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result word on channel %0d", out_if.out_channel);
        errors++;
      end else begin
        e = pending_pairs.pop_front();
        if (out_if.out_channel !== e.ch) begin
          $error("out_channel: expected %0d, got %0d", e.ch, out_if.out_channel);
          errors++;
        end
        if (out_if.direct_out !== e.dir) begin
          $error("direct_out: expected %0d, got %0d", e.dir, out_if.direct_out);
          errors++;
        end
        if (out_if.diffuse_out !== e.dif) begin
          $error("diffuse_out: expected %0d, got %0d", e.dif, out_if.diffuse_out);
          errors++;
        end
        if (out_if.saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, out_if.saturated);
          errors++;
        end
        if (e.sat) n_sat++;
      end
    end
    out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: the slowest legal run is far below this.
  initial begin
    #40ms;
    $display("FAIL multichannel_fir_decorrelator_unit");
    $finish;
  end

  initial begin
    int unsigned delays [5] = '{0, DELAY_DEPTH - 1, 1, 256, 0};
    stim_row_t row;
    in_if.valid = 1'b0;
    in_if.command = CMD_PROCESS;
    in_if.channel = '0;
    in_if.direct_sample = '0;
    in_if.diffuse_sample = '0;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    comp_delay = 256;
    for (int c = 0; c < CHANNELS; c++) begin
      delay_wp[c] = 0;
      hist_head[c] = 0;
      for (int i = 0; i < DELAY_DEPTH; i++) delay_line[c][i] = '0;
      for (int i = 0; i < TAPS; i++) hist_mem[c][i] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every tap before any pair is processed; the clearing pass
    // after reset simply holds ready low for a while.
    src_idle_pct = 24;
    snk_idle_pct = 56;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        row = '{CMD_LOAD, CH_W'(c), sample_t'($urandom), sample_t'($urandom),
                IDX_W'(t), pick_coef(c), 1'b0, '0, '0, 1'b0};
        if (c == 0) row.val = (t == 0) ? SAMPLE_MAX : 24'sd0;
        send_and_predict(row);
      end
    end

    for (int r = 0; r < DIR_ROWS; r++) send_and_predict(dir_tab[r]);
    drain_results();

    // Random phases: each one starts from a new delay setting.
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 56;
        snk_idle_pct = 24;
      end else if (ph == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_delay((ph == 4) ? $urandom_range(2, DELAY_DEPTH - 2) : delays[ph]);
      for (int n = 0; n < 110; n++) begin
        row.ch    = CH_W'($urandom);
        row.idx   = IDX_W'($urandom);
        row.dir   = sample_t'($urandom);
        row.typed = 1'b0;
        case ($urandom_range(9))
          0: row.dif = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          1: row.dif = sample_t'($urandom) >>> 12;
          default: row.dif = sample_t'($urandom);
        endcase
        if ($urandom_range(99) < 15) begin
          row.cmd = CMD_LOAD;
          row.val = pick_coef(row.ch);
        end else begin
          row.cmd = CMD_PROCESS;
          row.val = sample_t'($urandom);
        end
        send_and_predict(row);
      end
      drain_results();
    end

    if (pending_pairs.size() != 0) errors++;
    $display("Covered %0d filtered pairs (%0d clipped) and %0d tap loads", n_pairs, n_sat,
             n_loads);
    $display("across five delay settings and three handshake pressure mixes.");
    if (errors == 0) begin
      $display("PASS multichannel_fir_decorrelator_unit");
    end else begin
      $display("FAIL multichannel_fir_decorrelator_unit");
    end
    $finish;
  end

endmodule

### multichannel_fir_decorrelator_unit.f
+incdir+rtl/core
rtl/core/mfd_pkg.sv
rtl/core/mfd_if.sv
rtl/core/mfd_front.sv
rtl/core/mfd_queue.sv
rtl/core/mfd_back.sv
rtl/core/multichannel_fir_decorrelator_unit.sv
rtl/core/mfd_checker.sv
tb/sv/tb.sv
